// File: rtl/core/wcpt_pkg.sv
// wcpt_pkg: shared types and codes for the wall clock plausibility tracker
// status codes, register indexes, beat and configuration structs; no dependencies
`default_nettype none

package wcpt_pkg;

	localparam int WALL_W  = 64;
	localparam int MONO_W  = 32;
	localparam int STAT_W  = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [STAT_W-1:0] ST_NOT_INIT    = 3'd0;
	localparam logic [STAT_W-1:0] ST_WAITING     = 3'd1;
	localparam logic [STAT_W-1:0] ST_READY       = 3'd2;
	localparam logic [STAT_W-1:0] ST_IMPLAUSIBLE = 3'd3;
	localparam logic [STAT_W-1:0] ST_REGRESSED   = 3'd4;
	localparam logic [STAT_W-1:0] ST_STALE       = 3'd5;

	localparam logic [CFG_IDX_W-1:0] REG_NODE_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_MS       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_MS       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAG_TOL_MS   = 2'd3;

	localparam logic           RST_NODE_PRESENT = 1'b1;
	localparam logic [WALL_W-1:0] RST_MIN_MS    = 64'd1577836800000;
	localparam logic [WALL_W-1:0] RST_MAX_MS    = 64'd4102444800000;
	localparam logic [MONO_W-1:0] RST_LAG_TOL_MS = 32'd1000;

	localparam logic OP_SYNC = 1'b0;
	localparam logic OP_TICK = 1'b1;

	typedef struct packed {
		logic              op;
		logic              sample_valid;
		logic [WALL_W-1:0] wall_ms;
		logic [MONO_W-1:0] mono_ms;
	} item_t;

	typedef struct packed {
		logic [STAT_W-1:0] status;
		logic [WALL_W-1:0] protocol_ms;
		logic              advanced;
	} result_t;

	typedef struct packed {
		logic              node_present;
		logic [WALL_W-1:0] min_ms;
		logic [WALL_W-1:0] max_ms;
		logic [MONO_W-1:0] lag_tol_ms;
	} cfg_t;

endpackage

`default_nettype wire

// File: rtl/core/wcpt_if.sv
// wcpt_item_if and wcpt_result_if: valid/ready channels of the tracker
// depends on wcpt_pkg for field widths
`default_nettype none

interface wcpt_item_if import wcpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              op;
	logic              sample_valid;
	logic [WALL_W-1:0] wall_ms;
	logic [MONO_W-1:0] mono_ms;

	modport source (output valid, output op, output sample_valid, output wall_ms,
		output mono_ms, input ready);
	modport sink (input valid, input op, input sample_valid, input wall_ms,
		input mono_ms, output ready);
endinterface

interface wcpt_result_if import wcpt_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [WALL_W-1:0] protocol_ms;
	logic              advanced;

	modport source (output valid, output status, output protocol_ms, output advanced,
		input ready);
	modport sink (input valid, input status, input protocol_ms, input advanced,
		output ready);
endinterface

`default_nettype wire

// File: rtl/core/wcpt_cfg.sv
// wcpt_cfg: configuration registers of the tracker, written through a plain write port
// depends on wcpt_pkg
`default_nettype none

module wcpt_cfg import wcpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_present <= RST_NODE_PRESENT;
			cfg_q.min_ms       <= RST_MIN_MS;
			cfg_q.max_ms       <= RST_MAX_MS;
			cfg_q.lag_tol_ms   <= RST_LAG_TOL_MS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_NODE_PRESENT: cfg_q.node_present <= cfg_data[0];
				REG_MIN_MS:       cfg_q.min_ms       <= cfg_data[WALL_W-1:0];
				REG_MAX_MS:       cfg_q.max_ms       <= cfg_data[WALL_W-1:0];
				REG_LAG_TOL_MS:   cfg_q.lag_tol_ms   <= cfg_data[MONO_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: rtl/core/wcpt_core.sv
// wcpt_core: tracker state and the combinational evaluation of one staged item
// depends on wcpt_pkg; fed by the input stage of the top level
`default_nettype none

module wcpt_core import wcpt_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  fire,
	input  wire item_t item,
	input  wire cfg_t  cfg,
	output result_t    res
);

	logic [STAT_W-1:0] state_q, state_d;
	logic              mono_anchored_q, mono_anchored_d;
	logic              wall_anchored_q, wall_anchored_d;
	logic [MONO_W-1:0] last_mono_q, last_mono_d;
	logic [WALL_W-1:0] last_protocol_q, last_protocol_d;
	logic [WALL_W-1:0] last_wall_q, last_wall_d;

	logic              trusted;
	logic              latched;
	logic [MONO_W-1:0] elapsed;
	logic [WALL_W:0]   sum;
	logic [WALL_W-1:0] expected;
	logic [WALL_W-1:0] t;
	logic [WALL_W-1:0] lag;
	logic [WALL_W-1:0] proto;
	logic              out_of_range;
	logic              regress;
	logic              stale;
	logic              proto_high;
	logic              accept;

	assign trusted  = (item.op == OP_SYNC) || item.sample_valid;
	assign latched  = (state_q == ST_IMPLAUSIBLE) || (state_q == ST_REGRESSED) ||
		(state_q == ST_STALE);
	assign elapsed  = item.mono_ms - last_mono_q;
	assign sum      = {1'b0, last_protocol_q} + {{(WALL_W+1-MONO_W){1'b0}}, elapsed};
	assign expected = sum[WALL_W] ? {WALL_W{1'b1}} : sum[WALL_W-1:0];
	assign t        = trusted ? item.wall_ms : expected;
	assign lag      = expected - t;

	assign out_of_range = (t < cfg.min_ms) || (t >= cfg.max_ms);
	assign regress      = trusted && wall_anchored_q && (t < last_wall_q);
	assign stale        = trusted && mono_anchored_q && (t < expected) &&
		(lag > {{(WALL_W-MONO_W){1'b0}}, cfg.lag_tol_ms});
	assign proto        = (mono_anchored_q && (expected > t)) ? expected : t;
	assign proto_high   = proto >= cfg.max_ms;

	always_comb begin
		state_d         = state_q;
		mono_anchored_d = mono_anchored_q;
		wall_anchored_d = wall_anchored_q;
		last_mono_d     = last_mono_q;
		last_protocol_d = last_protocol_q;
		last_wall_d     = last_wall_q;
		accept          = 1'b0;
		if (!cfg.node_present) begin
			state_d = ST_NOT_INIT;
		end else if (trusted || (!latched && mono_anchored_q)) begin
			if (out_of_range) begin
				state_d = ST_IMPLAUSIBLE;
			end else if (regress) begin
				state_d = ST_REGRESSED;
			end else if (stale) begin
				state_d = ST_STALE;
			end else if (proto_high) begin
				state_d = ST_IMPLAUSIBLE;
			end else begin
				accept          = 1'b1;
				state_d         = ST_READY;
				mono_anchored_d = 1'b1;
				last_mono_d     = item.mono_ms;
				last_protocol_d = proto;
				if (trusted) begin
					wall_anchored_d = 1'b1;
					last_wall_d     = t;
				end
			end
		end else if (!latched) begin
			state_d = ST_WAITING;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_WAITING;
			mono_anchored_q <= 1'b0;
			wall_anchored_q <= 1'b0;
			last_mono_q     <= '0;
			last_protocol_q <= '0;
			last_wall_q     <= '0;
		end else if (fire) begin
			state_q         <= state_d;
			mono_anchored_q <= mono_anchored_d;
			wall_anchored_q <= wall_anchored_d;
			last_mono_q     <= last_mono_d;
			last_protocol_q <= last_protocol_d;
			last_wall_q     <= last_wall_d;
		end
	end

	assign res.status      = state_d;
	assign res.protocol_ms = accept ? proto : '0;
	assign res.advanced    = accept;

`ifndef SYNTHESIS
	a_adv_ready: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.advanced |-> res.status == ST_READY)
		else $error("advanced beat without ready status");
	a_adv_anchors: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.advanced |=> mono_anchored_q &&
		last_protocol_q == $past(res.protocol_ms))
		else $error("accepted time not stored");
	a_no_node: assert property (@(posedge clk) disable iff (!arst_n)
		fire && !cfg.node_present |=> state_q == ST_NOT_INIT &&
		$stable(last_protocol_q) && $stable(mono_anchored_q))
		else $error("state changed without a node");
	a_wall_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		fire && res.advanced && trusted && wall_anchored_q |=>
		last_wall_q >= $past(last_wall_q))
		else $error("trusted wall time went backward");
`endif

endmodule

`default_nettype wire

// File: rtl/core/wall_clock_plausibility_tracker.sv
// Wall clock plausibility tracker: keeps a protocol time from trusted wall samples and a
// free-running 32-bit millisecond counter. One item is taken every clock unless the result
// side stalls; the result passes the input stage and output registers, with no bubbles while
// the result side keeps taking beats. The rate is set by the state loop in wcpt_core, which
// checks, extrapolates and stores one item per cycle when fire is set. Configuration writes land
// in the next cycle and are meant to happen only while no item is in flight.
// depends on wcpt_pkg, wcpt_if, wcpt_cfg, wcpt_core
`default_nettype none

module wall_clock_plausibility_tracker import wcpt_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	wcpt_item_if.sink                  item,
	wcpt_result_if.source              result
);

	cfg_t    cfg;
	item_t   item_s1;
	logic    valid_s1;
	result_t res;
	result_t res_q;
	logic    res_valid_q;
	logic    advance;
	logic    fire;

	wcpt_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// stage moves when the output register is empty or being drained
	assign advance    = !res_valid_q || result.ready;
	assign fire       = valid_s1 && advance;
	assign item.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			item_s1.op           <= item.op;
			item_s1.sample_valid <= item.sample_valid;
			item_s1.wall_ms      <= item.wall_ms;
			item_s1.mono_ms      <= item.mono_ms;
		end
	end

	wcpt_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_q <= res;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.status      = res_q.status;
	assign result.protocol_ms = res_q.protocol_ms;
	assign result.advanced    = res_q.advanced;

endmodule

`default_nettype wire
